@@ sv/gradient_optimizer_update_macros.svh @@
// Assertion macros for the gradient optimizer update block.
// Used by the top level; expects signals clk and arst_n in scope.
`ifndef GRADIENT_OPTIMIZER_UPDATE_MACROS_SVH
`define GRADIENT_OPTIMIZER_UPDATE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define GOU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gradient optimizer check failed");

// Next-cycle implication, checked out of reset.
`define GOU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gradient optimizer check failed");

`endif

@@ sv/gou_pkg.sv @@
// Package for the gradient optimizer update block: codes, widths, item types.
// No dependencies; used by every module of the block.
`default_nettype none

package gou_pkg;

	localparam logic signed [25:0] ONE_Q24 = 26'sd16777216;
	localparam logic [24:0] ONE_Q24_U = 25'd16777216;

	localparam int DIV_NUM_W = 56;
	localparam int DIV_DEN_W = 28;
	localparam int DIV_QUO_W = 32;
	localparam int SQRT_RAD_W = 56;

	localparam logic [1:0] MODE_RST = 2'd0;
	localparam logic [24:0] LR_RST = 25'd16777;
	localparam logic [24:0] B1_RST = 25'd15099494;
	localparam logic [24:0] B2_RST = 25'd16760439;
	localparam logic [24:0] B1P_RST = 25'd15099494;
	localparam logic [24:0] B2P_RST = 25'd16760439;
	localparam logic [24:0] L2_RST = 25'd0;
	localparam logic [30:0] GSCALE_RST = 31'd16777216;

	typedef enum logic [1:0] {
		MODE_ADAM,
		MODE_SGD,
		MODE_MOMENTUM,
		MODE_HOLD
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE,
		REG_LR,
		REG_B1,
		REG_B2,
		REG_B1P,
		REG_B2P,
		REG_L2,
		REG_GSCALE
	} reg_idx_t;

	typedef struct packed {
		logic               fwd;
		logic        [30:0] v;
		logic signed [31:0] m;
		logic signed [31:0] w;
	} item_t;

	typedef struct packed {
		logic               sz;
		logic               neg;
		logic signed [31:0] step;
		logic               fwd;
		logic        [30:0] v;
		logic signed [31:0] m;
		logic signed [31:0] w;
	} side_t;

	typedef struct packed {
		logic               zd;
		logic signed [31:0] fd;
		logic        [30:0] v;
		logic signed [31:0] m;
		logic signed [31:0] nw;
	} out_t;

endpackage

`default_nettype wire

@@ sv/gou_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
// Depends on gou_pkg for default widths.
`default_nettype none

module gou_div #(
	parameter int NUM_W = gou_pkg::DIV_NUM_W,
	parameter int DEN_W = gou_pkg::DIV_DEN_W,
	parameter int QUO_W = gou_pkg::DIV_QUO_W
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [QUO_W-1:0] quo,
	output logic             ovf
);

	logic [DEN_W-1:0] rem_s [QUO_W+1];
	logic [QUO_W-1:0] quo_s [QUO_W+1];
	logic [DEN_W-1:0] den_s [QUO_W+1];
	logic             ovf_s [QUO_W+1];

	// Flag a quotient that does not fit before any step is taken.
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= DEN_W'(num[NUM_W-1:QUO_W]);
			quo_s[0] <= num[QUO_W-1:0];
			den_s[0] <= den;
			ovf_s[0] <= DEN_W'(num[NUM_W-1:QUO_W]) >= den;
		end
	end

	for (genvar k = 1; k <= QUO_W; k++) begin : g_step
		logic [DEN_W:0] trial;
		logic           ge;

		assign trial = {rem_s[k-1], quo_s[k-1][QUO_W-1]};
		assign ge    = trial >= {1'b0, den_s[k-1]};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k] <= ge ? DEN_W'(trial - {1'b0, den_s[k-1]}) : trial[DEN_W-1:0];
				quo_s[k] <= {quo_s[k-1][QUO_W-2:0], ge};
				den_s[k] <= den_s[k-1];
				ovf_s[k] <= ovf_s[k-1];
			end
		end
	end

	assign quo = quo_s[QUO_W];
	assign ovf = ovf_s[QUO_W];

endmodule

`default_nettype wire

@@ sv/gou_sqrt.sv @@
// Pipelined integer square root, one root bit per stage (floor of the root).
// Depends on gou_pkg for the default radicand width.
`default_nettype none

module gou_sqrt #(
	parameter int RAD_W = gou_pkg::SQRT_RAD_W
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [RAD_W-1:0]     rad,
	output logic [RAD_W/2-1:0]   root
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic [RAD_W-1:0]  rad_s  [ROOT_W];
	logic [REM_W-1:0]  rem_s  [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [RAD_W-1:0]  rad_p;
		logic [REM_W-1:0]  rem_p;
		logic [ROOT_W-1:0] root_p;
		logic [REM_W+1:0]  part;
		logic [REM_W+1:0]  trial;
		logic              ge;

		if (k == 0) begin : g_first
			assign rad_p  = rad;
			assign rem_p  = '0;
			assign root_p = '0;
		end else begin : g_next
			assign rad_p  = rad_s[k-1];
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
		end

		// Bring down two radicand bits, try root*4+1.
		assign part  = {rem_p, rad_p[RAD_W-1 -: 2]};
		assign trial = (REM_W+2)'({root_p, 2'b01});
		assign ge    = part >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[k]  <= {rad_p[RAD_W-3:0], 2'b00};
				rem_s[k]  <= ge ? REM_W'(part - trial) : REM_W'(part);
				root_s[k] <= {root_p[ROOT_W-2:0], ge};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

`default_nettype wire

@@ sv/gradient_optimizer_update.sv @@
// Top level of the gradient optimizer update: register file, pipeline, output buffer.
// Depends on gou_pkg, gou_div, gou_sqrt and gradient_optimizer_update_macros.svh.
//
//  channel  | role        | payload, lowest bit first
//  ---------+-------------+---------------------------------------------------------
//  s_axis   | item in     | weight, gradient_sum, first_moment, second_moment, fwd en
//  m_axis   | item out    | new_weight, new moments, forward_delta, zero_divisor
//  apb      | config      | eight registers at byte address 4*index, writes and reads
//
// One item per cycle while the output buffer is not full. The depth is set
// by two 33-stage dividers (bias correction, then the Adam ratio) and a 28-stage root,
// each yielding one result bit per stage after the divider's first, overflow-check stage.
// Reset clears the valid bits and the output buffer and loads the register defaults.
// The whole pipeline holds only while the two-entry output buffer is full; a single
// waiting result does not stop acceptance.
`default_nettype none

`include "gradient_optimizer_update_macros.svh"

module gradient_optimizer_update (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] weight, [63:32] gradient_sum, [95:64] first_moment,
	// [126:96] second_moment, [127] forward_enable
	input  logic [127:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] new_weight, [63:32] new_first_moment, [94:64] new_second_moment,
	// [126:95] forward_delta, [127] zero_divisor
	output logic [127:0] m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int DIV_LAT  = gou_pkg::DIV_QUO_W + 1;
	localparam int SQRT_LAT = gou_pkg::SQRT_RAD_W / 2;
	localparam int ROOT_W   = gou_pkg::SQRT_RAD_W / 2;

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		if (x > 64'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (x < -64'sd2147483648)
			return 32'sh8000_0000;
		else
			return x[31:0];
	endfunction

	// Clamp a quotient magnitude so that the signed value fits 32 bits.
	function automatic logic [31:0] sat_mag(input logic [31:0] q, input logic ovf,
			input logic neg);
		logic [31:0] lim;
		lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		return (ovf || q > lim) ? lim : q;
	endfunction

	// ---------------------------------------------------------------- registers
	gou_pkg::mode_t mode_q;
	logic [24:0] lr_q, b1_q, b2_q, b1p_q, b2p_q, l2_q;
	logic [30:0] gscale_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= gou_pkg::mode_t'(gou_pkg::MODE_RST);
			lr_q     <= gou_pkg::LR_RST;
			b1_q     <= gou_pkg::B1_RST;
			b2_q     <= gou_pkg::B2_RST;
			b1p_q    <= gou_pkg::B1P_RST;
			b2p_q    <= gou_pkg::B2P_RST;
			l2_q     <= gou_pkg::L2_RST;
			gscale_q <= gou_pkg::GSCALE_RST;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				gou_pkg::REG_MODE:   mode_q   <= gou_pkg::mode_t'(pwdata[1:0]);
				gou_pkg::REG_LR:     lr_q     <= pwdata[24:0];
				gou_pkg::REG_B1:     b1_q     <= pwdata[24:0];
				gou_pkg::REG_B2:     b2_q     <= pwdata[24:0];
				gou_pkg::REG_B1P:    b1p_q    <= pwdata[24:0];
				gou_pkg::REG_B2P:    b2p_q    <= pwdata[24:0];
				gou_pkg::REG_L2:     l2_q     <= pwdata[24:0];
				gou_pkg::REG_GSCALE: gscale_q <= pwdata[30:0];
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			gou_pkg::REG_MODE:   prdata = 32'(mode_q);
			gou_pkg::REG_LR:     prdata = 32'(lr_q);
			gou_pkg::REG_B1:     prdata = 32'(b1_q);
			gou_pkg::REG_B2:     prdata = 32'(b2_q);
			gou_pkg::REG_B1P:    prdata = 32'(b1p_q);
			gou_pkg::REG_B2P:    prdata = 32'(b2p_q);
			gou_pkg::REG_L2:     prdata = 32'(l2_q);
			gou_pkg::REG_GSCALE: prdata = 32'(gscale_q);
		endcase
	end

	// Register-only terms; user keeps them stable while items flow (not enforced).
	logic signed [25:0] c1, c2, d1, d2;
	logic        [25:0] d1_mag, d2_mag;
	logic               d1_zero, d2_zero;

	assign c1      = gou_pkg::ONE_Q24 - $signed({1'b0, b1_q});
	assign c2      = gou_pkg::ONE_Q24 - $signed({1'b0, b2_q});
	assign d1      = gou_pkg::ONE_Q24 - $signed({1'b0, b1p_q});
	assign d2      = gou_pkg::ONE_Q24 - $signed({1'b0, b2p_q});
	assign d1_mag  = d1[25] ? 26'(-d1) : d1;
	assign d2_mag  = d2[25] ? 26'(-d2) : d2;
	assign d1_zero = b1p_q == gou_pkg::ONE_Q24_U;
	assign d2_zero = b2p_q == gou_pkg::ONE_Q24_U;

	// ------------------------------------------------------------ flow control
	logic en;
	logic [1:0] cnt_q;

	// Advance everything together unless the output buffer is full.
	assign en            = cnt_q != 2'd2;
	assign s_axis_tready = en;

	// ---------------------------------------------------------------- s1..s3
	gou_pkg::item_t     itm_in;
	logic signed [31:0] in_gs;

	assign itm_in.w   = s_axis_tdata[31:0];
	assign in_gs      = s_axis_tdata[63:32];
	assign itm_in.m   = s_axis_tdata[95:64];
	assign itm_in.v   = s_axis_tdata[126:96];
	assign itm_in.fwd = s_axis_tdata[127];

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10, v_s11;

	logic signed [63:0] prod_g_s1;
	logic signed [58:0] prod_l_s1;
	gou_pkg::item_t     itm_s1, itm_s2, itm_s3, itm_s4;
	logic signed [31:0] g1_s2, g_s3;
	logic signed [34:0] l2t_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			// Scale the gradient and form 2*l2*weight.
			prod_g_s1 <= in_gs * $signed({1'b0, gscale_q});
			prod_l_s1 <= itm_in.w * $signed({1'b0, l2_q, 1'b0});
			itm_s1    <= itm_in;
			g1_s2     <= sat32(64'($signed(prod_g_s1[63:24])));
			l2t_s2    <= $signed(prod_l_s1[58:24]);
			itm_s2    <= itm_s1;
			g_s3      <= sat32(64'(g1_s2) - 64'(l2t_s2));
			itm_s3    <= itm_s2;
		end
	end

	// ---------------------------------------------------------------- s4..s7
	logic signed [57:0] pb1m_s4, pc1g_s4, plrg_s4, pb2v_s4, pb2v_s5, pb2v_s6, pv2_s6;
	logic signed [63:0] pgg_s4;
	logic        [30:0] sq_s5;
	gou_pkg::side_t     side_s5, side_s6, side_s7, side_n5, side_n7;
	logic signed [58:0] sum_a, sum_m, sum_v;
	logic signed [31:0] m_adam, m_mom, step_sgd;
	logic signed [34:0] v_raw;
	logic        [30:0] sq_n, v_adam;

	always_comb begin
		sum_a    = 59'(pb1m_s4) + 59'(pc1g_s4);
		sum_m    = 59'(pb1m_s4) + 59'(plrg_s4);
		m_adam   = sat32(64'($signed(sum_a[58:24])));
		m_mom    = sat32(64'($signed(sum_m[58:24])));
		step_sgd = sat32(64'($signed(plrg_s4[57:24])));
		sq_n     = (pgg_s4[63:24] > 40'd2147483647) ? 31'h7FFF_FFFF : pgg_s4[54:24];

		side_n5      = '0;
		side_n5.w    = itm_s4.w;
		side_n5.v    = itm_s4.v;
		side_n5.fwd  = itm_s4.fwd;
		case (mode_q)
			gou_pkg::MODE_ADAM: begin
				side_n5.m    = m_adam;
				side_n5.step = '0;
			end
			gou_pkg::MODE_SGD: begin
				side_n5.m    = itm_s4.m;
				side_n5.step = step_sgd;
			end
			gou_pkg::MODE_MOMENTUM: begin
				side_n5.m    = m_mom;
				side_n5.step = m_mom;
			end
			default: begin
				side_n5.m    = itm_s4.m;
				side_n5.step = '0;
			end
		endcase

		// Second moment, clamped to its unsigned range.
		sum_v  = 59'(pb2v_s6) + 59'(pv2_s6);
		v_raw  = $signed(sum_v[58:24]);
		if (v_raw < 35'sd0)
			v_adam = '0;
		else if (v_raw > 35'sd2147483647)
			v_adam = 31'h7FFF_FFFF;
		else
			v_adam = v_raw[30:0];

		// Adam replaces the second moment; other modes pass it through.
		side_n7 = side_s6;
		if (mode_q == gou_pkg::MODE_ADAM)
			side_n7.v = v_adam;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pb1m_s4 <= $signed({1'b0, b1_q}) * itm_s3.m;
			pc1g_s4 <= c1 * g_s3;
			plrg_s4 <= $signed({1'b0, lr_q}) * g_s3;
			pgg_s4  <= g_s3 * g_s3;
			pb2v_s4 <= $signed({1'b0, b2_q}) * $signed({1'b0, itm_s3.v});
			itm_s4  <= itm_s3;
			sq_s5   <= sq_n;
			pb2v_s5 <= pb2v_s4;
			side_s5 <= side_n5;
			pv2_s6  <= c2 * $signed({1'b0, sq_s5});
			pb2v_s6 <= pb2v_s5;
			side_s6 <= side_s5;
			side_s7 <= side_n7;
		end
	end

	// ------------------------------------------------- bias-correction dividers
	logic [31:0] m_mag7;
	logic [31:0] q1, q2;
	logic        ovf1, ovf2;

	assign m_mag7 = side_s7.m[31] ? (~side_s7.m + 32'd1) : side_s7.m;

	gou_div u_div_m (
		.clk (clk),
		.en  (en),
		.num ({m_mag7, 24'd0}),
		.den (gou_pkg::DIV_DEN_W'(d1_mag)),
		.quo (q1),
		.ovf (ovf1)
	);

	gou_div u_div_v (
		.clk (clk),
		.en  (en),
		.num ({1'b0, side_s7.v, 24'd0}),
		.den (gou_pkg::DIV_DEN_W'(d2_mag)),
		.quo (q2),
		.ovf (ovf2)
	);

	gou_pkg::side_t dv_side_s [DIV_LAT];
	logic           dv_vld_s  [DIV_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			dv_side_s[0] <= side_s7;
			for (int k = 1; k < DIV_LAT; k++)
				dv_side_s[k] <= dv_side_s[k-1];
		end
	end

	// ---------------------------------------------------------------- s8
	logic [31:0]    mh_mag_s8;
	logic [30:0]    vh_s8;
	gou_pkg::side_t side_s8, side_n8;
	logic           neg1;

	assign neg1 = dv_side_s[DIV_LAT-1].m[31] ^ d1[25];

	always_comb begin
		side_n8     = dv_side_s[DIV_LAT-1];
		side_n8.neg = neg1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mh_mag_s8   <= sat_mag(q1, ovf1, neg1);
			side_s8     <= side_n8;
			// A negative divisor leaves a non-positive quotient: clamp to zero.
			if (d2[25])
				vh_s8 <= '0;
			else if (ovf2 || q2 > 32'h7FFF_FFFF)
				vh_s8 <= 31'h7FFF_FFFF;
			else
				vh_s8 <= q2[30:0];
		end
	end

	// ------------------------------------------------------------ square root
	logic [ROOT_W-1:0] root;

	gou_sqrt u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  ({1'b0, vh_s8, 24'd0}),
		.root (root)
	);

	gou_pkg::side_t sr_side_s [SQRT_LAT];
	logic [31:0]    sr_mag_s  [SQRT_LAT];
	logic           sr_vld_s  [SQRT_LAT];

	always_ff @(posedge clk) begin
		if (en) begin
			sr_side_s[0] <= side_s8;
			sr_mag_s[0]  <= mh_mag_s8;
			for (int k = 1; k < SQRT_LAT; k++) begin
				sr_side_s[k] <= sr_side_s[k-1];
				sr_mag_s[k]  <= sr_mag_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------ Adam ratio
	logic [31:0] q3;
	logic        ovf3;

	gou_div u_div_r (
		.clk (clk),
		.en  (en),
		.num ({sr_mag_s[SQRT_LAT-1], 24'd0}),
		.den (gou_pkg::DIV_DEN_W'(root)),
		.quo (q3),
		.ovf (ovf3)
	);

	gou_pkg::side_t d3_side_s [DIV_LAT];
	logic           d3_vld_s  [DIV_LAT];
	gou_pkg::side_t sr_side_n;

	// Mark a zero root so that the step is dropped later.
	always_comb begin
		sr_side_n    = sr_side_s[SQRT_LAT-1];
		sr_side_n.sz = root == '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d3_side_s[0] <= sr_side_n;
			for (int k = 1; k < DIV_LAT; k++)
				d3_side_s[k] <= d3_side_s[k-1];
		end
	end

	// -------------------------------------------------------------- s9..s11
	logic signed [31:0] r_s9, step_s11;
	logic signed [57:0] plr_s10;
	gou_pkg::side_t     side_s9, side_s10, side_s11;
	logic               zd_s11, zd_n;
	logic [31:0]        r_mag;
	logic signed [31:0] step_adam, step_n;

	assign r_mag     = sat_mag(q3, ovf3, d3_side_s[DIV_LAT-1].neg);
	assign step_adam = sat32(64'($signed(plr_s10[57:24])));
	assign zd_n      = (mode_q == gou_pkg::MODE_ADAM) && (d1_zero || d2_zero || side_s10.sz);
	assign step_n    = (mode_q == gou_pkg::MODE_ADAM) ? (zd_n ? 32'sd0 : step_adam)
		: side_s10.step;

	always_ff @(posedge clk) begin
		if (en) begin
			r_s9     <= d3_side_s[DIV_LAT-1].neg ? (~r_mag + 32'd1) : r_mag;
			side_s9  <= d3_side_s[DIV_LAT-1];
			plr_s10  <= $signed({1'b0, lr_q}) * r_s9;
			side_s10 <= side_s9;
			step_s11 <= step_n;
			zd_s11   <= zd_n;
			side_s11 <= side_s10;
		end
	end

	// Valid bits travel with the data.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			v_s11 <= 1'b0;
			for (int k = 0; k < DIV_LAT; k++) begin
				dv_vld_s[k] <= 1'b0;
				d3_vld_s[k] <= 1'b0;
			end
			for (int k = 0; k < SQRT_LAT; k++)
				sr_vld_s[k] <= 1'b0;
		end else if (en) begin
			v_s1 <= s_axis_tvalid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			dv_vld_s[0] <= v_s7;
			for (int k = 1; k < DIV_LAT; k++)
				dv_vld_s[k] <= dv_vld_s[k-1];
			v_s8 <= dv_vld_s[DIV_LAT-1];
			sr_vld_s[0] <= v_s8;
			for (int k = 1; k < SQRT_LAT; k++)
				sr_vld_s[k] <= sr_vld_s[k-1];
			d3_vld_s[0] <= sr_vld_s[SQRT_LAT-1];
			for (int k = 1; k < DIV_LAT; k++)
				d3_vld_s[k] <= d3_vld_s[k-1];
			v_s9 <= d3_vld_s[DIV_LAT-1];
			v_s10 <= v_s9;
			v_s11 <= v_s10;
		end
	end

	// ---------------------------------------------------------- output buffer
	gou_pkg::out_t out_n;
	gou_pkg::out_t ent_q [2];
	logic          wr_ptr_q, rd_ptr_q;
	logic          push, pop;

	always_comb begin
		out_n.nw = sat32(64'(side_s11.w) + 64'(step_s11));
		out_n.m  = side_s11.m;
		out_n.v  = side_s11.v;
		out_n.fd = side_s11.fwd ? step_s11 : 32'sd0;
		out_n.zd = zd_s11;
	end

	assign push          = en && v_s11;
	assign m_axis_tvalid = cnt_q != 2'd0;
	assign pop           = m_axis_tvalid && m_axis_tready;
	assign m_axis_tdata  = ent_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_ptr_q] <= out_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

	// -------------------------------------------------------------- checks
	`GOU_ASSERT_NXT(a_stall_holds, !en && v_s11, v_s11 && $stable(step_s11))
	`GOU_ASSERT_IMP(a_flag_adam_only, v_s11 && zd_s11, mode_q == gou_pkg::MODE_ADAM)
	`GOU_ASSERT_NXT(a_cnt_moves_by_one, 1'b1, 2'(cnt_q - $past(cnt_q)) != 2'd2)

endmodule

`default_nettype wire
